FILE: hw/rtl/hvn_pkg.sv
// Shared types, constants and helpers for the heightmap vertex normal block.
package hvn_pkg;

	localparam logic [6:0]  GRID_RESET = 7'd16;
	localparam logic [15:0] INV_RESET  = 16'd128;
	localparam logic        REG_GRID   = 1'b0;
	localparam logic        REG_INV    = 1'b1;
	localparam int          UNIT_BITS  = 30;
	localparam int          ONE_Q16    = 65536;
	localparam int          QUOT_BITS  = 15;
	localparam int          ROOT_STEPS = 32;

	typedef struct packed {
		logic last;
		logic endg;
	} flags_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SEL,
		F_READ,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SHIFT,
		B_SQ,
		B_SQRT,
		B_DLOAD,
		B_DIV,
		B_OUT
	} back_state_t;

	// Row slot that lies 'off' rows above slot 's', modulo three.
	function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] off);
		logic [2:0] t;
		t = {1'b0, s} + 3'd3 - {1'b0, off};
		if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

endpackage

FILE: hw/rtl/hvn_ram.sv
// Generic single write, single read RAM with registered read data.
module hvn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 195
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/hvn_front.sv
// Front end: raster counters, line store, job selection and neighbor fetch.
module hvn_front #(
	parameter int MAX_GRID    = 64,
	parameter int HEIGHT_BITS = 16,
	parameter int CW          = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [HEIGHT_BITS-1:0] height_sample,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [CW-1:0]                 grid,
	input  logic                          restart,
	output logic                          job_valid,
	input  logic                          job_full,
	output logic signed [HEIGHT_BITS:0]   job_dx,
	output logic signed [HEIGHT_BITS:0]   job_dz,
	output logic [CW-1:0]                 job_col,
	output logic [CW-1:0]                 job_row,
	output hvn_pkg::flags_t               job_flags
);

	localparam int SPAN  = MAX_GRID + 1;
	localparam int DEPTH = 3 * SPAN;
	localparam int RAW   = $clog2(DEPTH);
	localparam int HB    = HEIGHT_BITS;

	hvn_pkg::front_state_t state_q, state_d;

	logic [CW-1:0] col_q, row_q, x_q, z_q, vx_q, vz_q;
	logic [1:0]    slot_q, sz_q;
	logic [2:0]    jm_q;
	logic [2:0]    rc_q;
	hvn_pkg::flags_t flags_q;
	logic signed [HB-1:0] nb_q [4];

	logic [CW-1:0] x_c, z_c, cx, rr;
	logic          accept, fcol, frow;
	logic [1:0]    off, rslot;
	logic [RAW-1:0] waddr, raddr;
	logic [HB-1:0] rdata;

	function automatic logic [RAW-1:0] slot_base(input logic [1:0] s);
		case (s)
			2'd0:    return '0;
			2'd1:    return RAW'(SPAN);
			default: return RAW'(2 * SPAN);
		endcase
	endfunction

	assign accept       = (state_q == hvn_pkg::F_IDLE) && sample_valid;
	assign sample_stall = (state_q != hvn_pkg::F_IDLE);
	assign x_c  = (col_q > grid) ? grid : col_q;
	assign z_c  = (row_q > grid) ? grid : row_q;
	assign fcol = (x_c == grid);
	assign frow = (z_c == grid);
	assign waddr = slot_base(slot_q) + RAW'(x_c);

	always_comb begin
		cx = vx_q;
		rr = vz_q;
		case (rc_q)
			3'd0:    cx = (vx_q == '0) ? '0 : vx_q - 1'b1;
			3'd1:    cx = (vx_q == grid) ? grid : vx_q + 1'b1;
			3'd2:    rr = (vz_q == '0) ? '0 : vz_q - 1'b1;
			default: rr = (vz_q == grid) ? grid : vz_q + 1'b1;
		endcase
		off   = 2'(z_q - rr);
		rslot = hvn_pkg::slot_back(sz_q, off);
		raddr = slot_base(rslot) + RAW'(cx);
	end

	hvn_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (height_sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign job_valid = (state_q == hvn_pkg::F_PUSH);
	assign job_dx    = {nb_q[1][HB-1], nb_q[1]} - {nb_q[0][HB-1], nb_q[0]};
	assign job_dz    = {nb_q[3][HB-1], nb_q[3]} - {nb_q[2][HB-1], nb_q[2]};
	assign job_col   = vx_q;
	assign job_row   = vz_q;
	assign job_flags = flags_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hvn_pkg::F_IDLE: begin
				if (accept && (row_q != '0 || frow)) begin
					state_d = hvn_pkg::F_SEL;
				end
			end
			hvn_pkg::F_SEL:  state_d = hvn_pkg::F_READ;
			hvn_pkg::F_READ: begin
				if (rc_q == 3'd4) begin
					state_d = hvn_pkg::F_PUSH;
				end
			end
			hvn_pkg::F_PUSH: begin
				if (!job_full) begin
					state_d = (jm_q != '0) ? hvn_pkg::F_SEL : hvn_pkg::F_IDLE;
				end
			end
			default: state_d = hvn_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvn_pkg::F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			jm_q    <= '0;
			rc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end else if (accept) begin
				if (fcol) begin
					col_q <= '0;
					if (frow) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= z_c + 1'b1;
						slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
					end
				end else begin
					col_q <= x_c + 1'b1;
					row_q <= z_c;
				end
			end
			if (accept) begin
				jm_q <= {frow && fcol, frow && (x_c != '0), z_c != '0};
			end else if (state_q == hvn_pkg::F_SEL) begin
				if (jm_q[0]) begin
					jm_q[0] <= 1'b0;
				end else if (jm_q[1]) begin
					jm_q[1] <= 1'b0;
				end else begin
					jm_q[2] <= 1'b0;
				end
			end
			if (state_q == hvn_pkg::F_SEL) begin
				rc_q <= '0;
			end else if (state_q == hvn_pkg::F_READ) begin
				rc_q <= rc_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= x_c;
			z_q  <= z_c;
			sz_q <= slot_q;
		end
		if (state_q == hvn_pkg::F_SEL) begin
			if (jm_q[0]) begin
				vx_q <= x_q;
				vz_q <= z_q - 1'b1;
				flags_q.last <= (jm_q[2:1] == 2'b00);
				flags_q.endg <= 1'b0;
			end else if (jm_q[1]) begin
				vx_q <= x_q - 1'b1;
				vz_q <= z_q;
				flags_q.last <= !jm_q[2];
				flags_q.endg <= 1'b0;
			end else begin
				vx_q <= grid;
				vz_q <= grid;
				flags_q.last <= 1'b1;
				flags_q.endg <= 1'b1;
			end
		end
		if (state_q == hvn_pkg::F_READ && rc_q != 3'd0) begin
			nb_q[2'(rc_q - 3'd1)] <= rdata;
		end
	end

endmodule

FILE: hw/rtl/hvn_queue.sv
// Short job queue between the front end and the normalizer.
module hvn_queue #(
	parameter int WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] head
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == (PW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = ent_q[rp_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/hvn_back.sv
// Back end: gradient scaling, sum of squares, integer square root and division.
module hvn_back #(
	parameter int HEIGHT_BITS = 16,
	parameter int CW          = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_present,
	output logic                        job_pop,
	input  logic signed [HEIGHT_BITS:0] job_dx,
	input  logic signed [HEIGHT_BITS:0] job_dz,
	input  logic [CW-1:0]               job_col,
	input  logic [CW-1:0]               job_row,
	input  hvn_pkg::flags_t             job_flags,
	input  logic [15:0]                 inv,
	output logic                        normal_valid,
	input  logic                        normal_stall,
	output logic signed [15:0]          normal_x,
	output logic [14:0]                 normal_y,
	output logic signed [15:0]          normal_z,
	output logic [CW-1:0]               vertex_col,
	output logic [CW-1:0]               vertex_row,
	output logic                        last_of_run,
	output logic                        end_of_grid
);

	localparam int HB   = HEIGHT_BITS;
	localparam int AW   = HB + 16;
	localparam int MW   = (AW > 31) ? AW : 31;
	localparam int SMAX = MW - hvn_pkg::UNIT_BITS;
	localparam int UB   = hvn_pkg::UNIT_BITS;
	localparam int NW   = 47;

	hvn_pkg::back_state_t state_q;

	logic [HB-1:0]   adx_q, adz_q;
	logic            negx_q, negz_q;
	logic [AW-1:0]   ax_q, az_q;
	logic [UB-1:0]   mx_q, my_q, mz_q;
	logic [2*UB-1:0] prod_q;
	logic [63:0]     acc_q, res_q, bit_q;
	logic [4:0]      it_q;
	logic [1:0]      k_q;
	logic [3:0]      di_q;
	logic [NW-1:0]   num_q;
	logic [14:0]     quo_q, nx_q, ny_q;
	logic [CW-1:0]   col_q, row_q;
	hvn_pkg::flags_t flags_q;

	logic [HB:0]     adx_c, adz_c;
	logic [MW-1:0]   mxw, axw, azw, ayw, tx, tz, ty;
	logic [UB-1:0]   sq_op;
	logic [63:0]     trial;
	logic [UB-1:0]   mk;
	logic [NW-1:0]   dsh;

	assign adx_c = job_dx[HB] ? -job_dx : job_dx;
	assign adz_c = job_dz[HB] ? -job_dz : job_dz;
	assign job_pop = (state_q == hvn_pkg::B_IDLE) && job_present;

	always_comb begin
		axw = MW'(ax_q);
		azw = MW'(az_q);
		ayw = MW'(hvn_pkg::ONE_Q16);
		mxw = (axw > azw) ? axw : azw;
		if (ayw > mxw) begin
			mxw = ayw;
		end
		tx = axw;
		tz = azw;
		ty = ayw;
		for (int i = SMAX; i >= 0; i--) begin
			if (((mxw >> i) >> UB) == '0) begin
				tx = axw >> i;
				tz = azw >> i;
				ty = ayw >> i;
			end
		end
	end

	always_comb begin
		case (it_q[1:0])
			2'd0:    sq_op = mx_q;
			2'd1:    sq_op = my_q;
			default: sq_op = mz_q;
		endcase
		case (k_q)
			2'd0:    mk = mx_q;
			2'd1:    mk = my_q;
			default: mk = mz_q;
		endcase
		trial = res_q + bit_q;
		dsh   = NW'(res_q[31:0]) << di_q;
	end

	assign normal_valid = (state_q == hvn_pkg::B_OUT);
	assign normal_x     = negx_q ? -{1'b0, nx_q} : {1'b0, nx_q};
	assign normal_y     = ny_q;
	assign normal_z     = negz_q ? -{1'b0, quo_q} : {1'b0, quo_q};
	assign vertex_col   = col_q;
	assign vertex_row   = row_q;
	assign last_of_run  = flags_q.last;
	assign end_of_grid  = flags_q.endg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvn_pkg::B_IDLE;
			it_q    <= '0;
			k_q     <= '0;
			di_q    <= '0;
		end else begin
			case (state_q)
				hvn_pkg::B_IDLE: begin
					if (job_present) begin
						state_q <= hvn_pkg::B_MUL;
					end
				end
				hvn_pkg::B_MUL:   state_q <= hvn_pkg::B_SHIFT;
				hvn_pkg::B_SHIFT: begin
					it_q    <= '0;
					state_q <= hvn_pkg::B_SQ;
				end
				hvn_pkg::B_SQ: begin
					if (it_q == 5'd3) begin
						it_q    <= '0;
						state_q <= hvn_pkg::B_SQRT;
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
				hvn_pkg::B_SQRT: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(hvn_pkg::ROOT_STEPS - 1)) begin
						k_q     <= '0;
						state_q <= hvn_pkg::B_DLOAD;
					end
				end
				hvn_pkg::B_DLOAD: begin
					di_q    <= 4'(hvn_pkg::QUOT_BITS - 1);
					state_q <= hvn_pkg::B_DIV;
				end
				hvn_pkg::B_DIV: begin
					if (di_q == '0) begin
						if (k_q == 2'd2) begin
							state_q <= hvn_pkg::B_OUT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= hvn_pkg::B_DLOAD;
						end
					end else begin
						di_q <= di_q - 4'd1;
					end
				end
				hvn_pkg::B_OUT: begin
					if (!normal_stall) begin
						state_q <= hvn_pkg::B_IDLE;
					end
				end
				default: state_q <= hvn_pkg::B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hvn_pkg::B_IDLE: begin
				adx_q   <= adx_c[HB-1:0];
				adz_q   <= adz_c[HB-1:0];
				negx_q  <= !job_dx[HB] && (job_dx != '0);
				negz_q  <= !job_dz[HB] && (job_dz != '0);
				col_q   <= job_col;
				row_q   <= job_row;
				flags_q <= job_flags;
			end
			hvn_pkg::B_MUL: begin
				ax_q <= {16'b0, adx_q} * {{HB{1'b0}}, inv};
				az_q <= {16'b0, adz_q} * {{HB{1'b0}}, inv};
			end
			hvn_pkg::B_SHIFT: begin
				mx_q  <= tx[UB-1:0];
				mz_q  <= tz[UB-1:0];
				my_q  <= ty[UB-1:0];
				acc_q <= '0;
			end
			hvn_pkg::B_SQ: begin
				prod_q <= sq_op * sq_op;
				if (it_q != '0) begin
					acc_q <= acc_q + 64'(prod_q);
				end
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			hvn_pkg::B_SQRT: begin
				if (acc_q >= trial) begin
					acc_q <= acc_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			hvn_pkg::B_DLOAD: begin
				num_q <= (NW'(mk) << 14) + NW'(res_q[31:1]);
				quo_q <= '0;
			end
			hvn_pkg::B_DIV: begin
				if (num_q >= dsh) begin
					num_q        <= num_q - dsh;
					quo_q[di_q]  <= 1'b1;
				end
				if (di_q == '0 && k_q == 2'd0) begin
					nx_q <= quo_q | ((num_q >= dsh) ? 15'd1 : 15'd0);
				end
				if (di_q == '0 && k_q == 2'd1) begin
					ny_q <= quo_q | ((num_q >= dsh) ? 15'd1 : 15'd0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/heightmap_vertex_normals.sv
// Top level of the heightmap vertex normal block: configuration and front/queue/back wiring.
// Heights arrive in raster order over a (grid_size+1) square vertex grid, one per accepted
// item; once the row below a vertex is in, the block returns that vertex's unit normal in
// Q1.14 (on the last row up to three normals per item). The front end takes one sample while
// idle, then for each normal selects the vertex, fetches its four neighbors through the single
// read port of the line store, and pushes the job. Per normal the normalizer takes the job,
// scales the gradients, sums the squares, takes the integer square root, runs three restoring
// divisions and holds the result while the output is stalled. A two-entry queue lets the front
// end run ahead of the normalizer, so the normalizer sets the sustained rate, and the input
// stalls whenever the front end is busy with a sample's jobs, including while it waits on a
// full queue. The line store needs no clearing after reset.
module heightmap_vertex_normals #(
	parameter int MAX_GRID    = 64,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 write_enable,
	input  logic                                 reg_index,
	input  logic [15:0]                          write_data,
	input  logic signed [HEIGHT_BITS-1:0]        height_sample,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	output logic signed [15:0]                   normal_x,
	output logic [14:0]                          normal_y,
	output logic signed [15:0]                   normal_z,
	output logic [$clog2(MAX_GRID+1)-1:0]        vertex_col,
	output logic [$clog2(MAX_GRID+1)-1:0]        vertex_row,
	output logic                                 last_of_run,
	output logic                                 end_of_grid,
	output logic                                 normal_valid,
	input  logic                                 normal_stall
);

	localparam int CW = $clog2(MAX_GRID + 1);
	localparam int HB = HEIGHT_BITS;
	localparam int JW = 2 * (HB + 1) + 2 * CW + $bits(hvn_pkg::flags_t);

	logic [6:0]  grid_q;
	logic [15:0] inv_q;
	logic [CW-1:0] grid_eff;
	logic          restart;

	logic                 f_valid, q_full, q_nonempty, b_pop;
	logic signed [HB:0]   f_dx, f_dz, b_dx, b_dz;
	logic [CW-1:0]        f_col, f_row, b_col, b_row;
	hvn_pkg::flags_t      f_flags, b_flags;
	logic [JW-1:0]        q_head;

	assign restart = write_enable && (reg_index == hvn_pkg::REG_GRID);

	always_comb begin
		if (grid_q == '0) begin
			grid_eff = CW'(1);
		end else if (32'(grid_q) > MAX_GRID) begin
			grid_eff = CW'(MAX_GRID);
		end else begin
			grid_eff = CW'(grid_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= hvn_pkg::GRID_RESET;
			inv_q  <= hvn_pkg::INV_RESET;
		end else if (write_enable) begin
			case (reg_index)
				hvn_pkg::REG_GRID: grid_q <= write_data[6:0];
				default:           inv_q  <= write_data;
			endcase
		end
	end

	hvn_front #(.MAX_GRID(MAX_GRID), .HEIGHT_BITS(HB), .CW(CW)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.height_sample (height_sample),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.grid          (grid_eff),
		.restart       (restart),
		.job_valid     (f_valid),
		.job_full      (q_full),
		.job_dx        (f_dx),
		.job_dz        (f_dz),
		.job_col       (f_col),
		.job_row       (f_row),
		.job_flags     (f_flags)
	);

	hvn_queue #(.WIDTH(JW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_data ({f_dx, f_dz, f_col, f_row, f_flags}),
		.full      (q_full),
		.pop       (b_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	assign {b_dx, b_dz, b_col, b_row, b_flags} = q_head;

	hvn_back #(.HEIGHT_BITS(HB), .CW(CW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_present  (q_nonempty),
		.job_pop      (b_pop),
		.job_dx       (b_dx),
		.job_dz       (b_dz),
		.job_col      (b_col),
		.job_row      (b_row),
		.job_flags    (b_flags),
		.inv          (inv_q),
		.normal_valid (normal_valid),
		.normal_stall (normal_stall),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.vertex_col   (vertex_col),
		.vertex_row   (vertex_row),
		.last_of_run  (last_of_run),
		.end_of_grid  (end_of_grid)
	);

endmodule
